/* hdl/uv_sphere_quad_tessellator_top_assert.svh */
// assertion macros for the uv sphere quad tessellator checker
// depends on a clk and an active-low rst_n in the scope of use
`ifndef UV_SPHERE_QUAD_TESSELLATOR_TOP_ASSERT_SVH
`define UV_SPHERE_QUAD_TESSELLATOR_TOP_ASSERT_SVH

// same-cycle implication
`define UVSQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UVSQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/uvsq_pkg.sv */
// types, constants and helper functions of the uv sphere quad tessellator
// no dependencies
package uvsq_pkg;

    localparam logic [1:0] REG_RADIUS   = 2'd0;
    localparam logic [1:0] REG_SEGMENTS = 2'd1;
    localparam logic [1:0] REG_RINGS    = 2'd2;

    // corner k steps one ring (dr) or one segment (ds) when bit k is set
    localparam logic [5:0] CORNER_DR = 6'b110010;
    localparam logic [5:0] CORNER_DS = 6'b101100;

    localparam logic [2:0] LAST_CORNER = 3'd5;

    localparam int PIPE_DEPTH = 13;
    localparam int DIV_LANES  = 3;
    localparam int SIN_LANES  = 4;
    localparam int SIN_STAGES = 7;

    // sine polynomial coefficients, q30, highest order first
    localparam logic [30:0] COEF [6] = '{
        31'd3864, 31'd172274, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
    };

    typedef struct packed {
        logic [8:0]  rem;
        logic [16:0] quo;
    } div_state_t;

    typedef struct packed {
        logic [14:0] f;
        logic        neg;
        logic [30:0] x2;
        logic [30:0] p;
    } sin_lane_t;

    typedef struct packed {
        logic [16:0] u;
        logic [16:0] v;
        logic        last;
        logic        err;
    } side_t;

    function automatic div_state_t div_chunk(input div_state_t s, input logic [5:0] bits,
                                             input int n, input logic [8:0] d);
        logic [9:0] t;
        div_state_t r;
        r = s;
        for (int i = 0; i < 6; i++) begin
            if (i < n) begin
                t = {r.rem, bits[5-i]};
                if (t >= {1'b0, d}) begin
                    t = t - {1'b0, d};
                    r.quo = {r.quo[15:0], 1'b1};
                end
                else begin
                    r.quo = {r.quo[15:0], 1'b0};
                end
                r.rem = t[8:0];
            end
        end
        return r;
    endfunction

    function automatic logic signed [15:0] rnd14(input logic signed [31:0] v);
        logic signed [31:0] t;
        t = v + (v[31] ? 32'sd8191 : 32'sd8192);
        return t[29:14];
    endfunction

    function automatic logic signed [15:0] rnd28(input logic signed [47:0] v);
        logic signed [47:0] t;
        t = v + (v[47] ? 48'sd134217727 : 48'sd134217728);
        return t[43:28];
    endfunction

endpackage

/* hdl/uv_sphere_quad_tessellator_top.sv */
// uv sphere quad tessellator: one quad address in, six vertices out
// depends on uvsq_pkg
//
// A quad (ring_index, segment_index) is accepted and expanded by a corner
// sequencer into six vertices, two triangles, one vertex per cycle while the
// output is not stalled, and the next quad is accepted as the sixth corner is
// issued; an out-of-range quad gives a single flagged word. Each vertex runs
// through a 14-stage pipeline (three stages of restoring division, seven of
// sine polynomial, three of scaling and rounding, one output register). The
// whole pipeline holds while a result waits on out_ready.
module uv_sphere_quad_tessellator_top #(
    parameter int MAX_SEGMENTS = 256,
    parameter int MAX_RINGS    = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         ring_index,
    input  logic [7:0]         segment_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic               last_vertex,
    output logic               index_error
);
    import uvsq_pkg::*;

    logic [14:0] radius_reg, radius_next;
    logic [8:0]  segments_reg, segments_next;
    logic [8:0]  rings_reg, rings_next;
    logic [8:0]  seg_eff, ring_eff;

    logic        busy_reg, busy_next;
    logic [2:0]  corner_reg, corner_next;
    logic [7:0]  qr_reg, qr_next;
    logic [7:0]  qs_reg, qs_next;
    logic        qerr_reg, qerr_next;
    logic        last_corner;
    logic        adv;

    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;
    side_t       side_reg [PIPE_DEPTH];
    side_t       side_next [PIPE_DEPTH];

    div_state_t  dv_reg [3][DIV_LANES];
    div_state_t  dv_next [3][DIV_LANES];
    logic [24:0] dn_reg [2][DIV_LANES];
    logic [24:0] dn_next [2][DIV_LANES];

    sin_lane_t   sn_reg [SIN_STAGES][SIN_LANES];
    sin_lane_t   sn_next [SIN_STAGES][SIN_LANES];
    logic signed [15:0] sv_reg [SIN_LANES];
    logic signed [15:0] sv_next [SIN_LANES];

    logic signed [31:0] p1_reg, p1_next, nx_reg, nx_next, nz_reg, nz_next, py_reg, py_next;
    logic signed [15:0] ct12_reg, ct12_next, st12_reg, st12_next, cp12_reg, cp12_next;
    logic signed [47:0] px_reg, px_next, pz_reg, pz_next;
    logic signed [15:0] nxo_reg, nxo_next, nyo_reg, nyo_next;
    logic signed [15:0] nzo_reg, nzo_next, pyo_reg, pyo_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next, pos_z_reg, pos_z_next;
    logic signed [15:0] norm_x_reg, norm_x_next, norm_y_reg, norm_y_next;
    logic signed [15:0] norm_z_reg, norm_z_next;
    logic [16:0]        tex_u_reg, tex_u_next, tex_v_reg, tex_v_next;
    logic               last_reg, last_next, err_reg, err_next;

    logic [8:0]  rr, ss;
    logic [24:0] dnum [DIV_LANES];
    logic [8:0]  ddiv [DIV_LANES];
    div_state_t  dinit;
    logic [15:0] ph [SIN_LANES];
    logic [14:0] arg;
    logic [61:0] hprod;
    logic [45:0] fprod;
    logic [31:0] rsum;
    logic [15:0] mag;
    logic signed [15:0] rad_s;

    assign seg_eff  = (int'(segments_reg) > MAX_SEGMENTS) ? 9'(MAX_SEGMENTS) : segments_reg;
    assign ring_eff = (int'(rings_reg) > MAX_RINGS) ? 9'(MAX_RINGS) : rings_reg;

    assign adv         = !out_valid_reg || out_ready;
    assign last_corner = qerr_reg || (corner_reg == LAST_CORNER);
    assign in_ready    = !busy_reg || (adv && last_corner);

    assign out_valid   = out_valid_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign pos_z       = pos_z_reg;
    assign norm_x      = norm_x_reg;
    assign norm_y      = norm_y_reg;
    assign norm_z      = norm_z_reg;
    assign tex_u       = tex_u_reg;
    assign tex_v       = tex_v_reg;
    assign last_vertex = last_reg;
    assign index_error = err_reg;

    always_comb
    begin
        radius_next   = radius_reg;
        segments_next = segments_reg;
        rings_next    = rings_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS:   radius_next   = cfg_data;
                REG_SEGMENTS: segments_next = cfg_data[8:0];
                REG_RINGS:    rings_next    = cfg_data[8:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        busy_next   = busy_reg;
        corner_next = corner_reg;
        qr_next     = qr_reg;
        qs_next     = qs_reg;
        qerr_next   = qerr_reg;
        if (adv && busy_reg)
        begin
            if (last_corner)
            begin
                busy_next   = 1'b0;
                corner_next = '0;
            end
            else
            begin
                corner_next = corner_reg + 3'd1;
            end
        end
        if (in_valid && in_ready)
        begin
            busy_next   = 1'b1;
            corner_next = '0;
            qr_next     = ring_index;
            qs_next     = segment_index;
            qerr_next   = ({1'b0, ring_index} >= ring_eff) || ({1'b0, segment_index} >= seg_eff);
        end
    end

    always_comb
    begin
        vld_next       = vld_reg;
        side_next      = side_reg;
        dv_next        = dv_reg;
        dn_next        = dn_reg;
        sn_next        = sn_reg;
        sv_next        = sv_reg;
        p1_next        = p1_reg;
        nx_next        = nx_reg;
        nz_next        = nz_reg;
        py_next        = py_reg;
        ct12_next      = ct12_reg;
        st12_next      = st12_reg;
        cp12_next      = cp12_reg;
        px_next        = px_reg;
        pz_next        = pz_reg;
        nxo_next       = nxo_reg;
        nyo_next       = nyo_reg;
        nzo_next       = nzo_reg;
        pyo_next       = pyo_reg;
        out_valid_next = out_valid_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        norm_x_next    = norm_x_reg;
        norm_y_next    = norm_y_reg;
        norm_z_next    = norm_z_reg;
        tex_u_next     = tex_u_reg;
        tex_v_next     = tex_v_reg;
        last_next      = last_reg;
        err_next       = err_reg;

        rr      = {1'b0, qr_reg} + {8'd0, CORNER_DR[corner_reg]};
        ss      = {1'b0, qs_reg} + {8'd0, CORNER_DS[corner_reg]};
        dnum[0] = {ss, 16'd0} + {16'd0, 1'b0, seg_eff[8:1]};
        dnum[1] = {rr, 16'd0} + {16'd0, 1'b0, ring_eff[8:1]};
        dnum[2] = {1'b0, rr, 15'd0} + {16'd0, 1'b0, ring_eff[8:1]};
        ddiv[0] = seg_eff;
        ddiv[1] = ring_eff;
        ddiv[2] = ring_eff;

        ph[0] = dv_reg[2][2].quo[15:0];
        ph[1] = dv_reg[2][2].quo[15:0] + 16'd16384;
        ph[2] = dv_reg[2][0].quo[15:0];
        ph[3] = dv_reg[2][0].quo[15:0] + 16'd16384;

        rad_s = signed'({1'b0, radius_reg});
        dinit = '0;
        arg   = '0;
        hprod = '0;
        fprod = '0;
        rsum  = '0;
        mag   = '0;

        if (adv)
        begin
            vld_next[0] = busy_reg;
            vld_next[PIPE_DEPTH-1:1] = vld_reg[PIPE_DEPTH-2:0];
            side_next[0] = '{u: '0, v: '0, last: last_corner, err: qerr_reg};
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                side_next[i] = side_reg[i-1];
            end
            side_next[3].u = dv_reg[2][0].quo;
            side_next[3].v = dv_reg[2][1].quo;

            // long division, 17 quotient bits over three stages
            for (int l = 0; l < DIV_LANES; l++)
            begin
                dinit.rem = {1'b0, dnum[l][24:17]};
                dinit.quo = '0;
                dv_next[0][l] = div_chunk(dinit, dnum[l][16:11], 6, ddiv[l]);
                dn_next[0][l] = dnum[l];
                dv_next[1][l] = div_chunk(dv_reg[0][l], dn_reg[0][l][10:5], 6, ddiv[l]);
                dn_next[1][l] = dn_reg[0][l];
                dv_next[2][l] = div_chunk(dv_reg[1][l], {dn_reg[1][l][4:0], 1'b0}, 5, ddiv[l]);
            end

            // quadrant fold and sine polynomial
            for (int l = 0; l < SIN_LANES; l++)
            begin
                arg = ph[l][14] ? 15'(15'd16384 - {1'b0, ph[l][13:0]}) : {1'b0, ph[l][13:0]};
                sn_next[0][l].f   = arg;
                sn_next[0][l].neg = ph[l][15];
                sn_next[0][l].x2  = 31'((32'(arg) * 32'(arg)) << 2);
                sn_next[0][l].p   = COEF[0];
                for (int i = 1; i < SIN_STAGES - 1; i++)
                begin
                    sn_next[i][l] = sn_reg[i-1][l];
                    hprod = 62'(sn_reg[i-1][l].x2) * 62'(sn_reg[i-1][l].p);
                    sn_next[i][l].p = COEF[i] - 31'(hprod >> 30);
                end
                sn_next[SIN_STAGES-1][l] = sn_reg[SIN_STAGES-2][l];
                fprod = 46'(sn_reg[SIN_STAGES-2][l].f) * 46'(sn_reg[SIN_STAGES-2][l].p);
                sn_next[SIN_STAGES-1][l].p = 31'(fprod >> 14);

                rsum = {1'b0, sn_reg[SIN_STAGES-1][l].p} + 32'd32768;
                mag  = rsum[31:16];
                if (mag > 16'd16384)
                begin
                    mag = 16'd16384;
                end
                sv_next[l] = sn_reg[SIN_STAGES-1][l].neg ? -signed'(mag) : signed'(mag);
            end

            // lanes: sin phi, cos phi, sin theta, cos theta
            p1_next   = rad_s * sv_reg[0];
            nx_next   = sv_reg[0] * sv_reg[3];
            nz_next   = sv_reg[0] * sv_reg[2];
            py_next   = rad_s * sv_reg[1];
            ct12_next = sv_reg[3];
            st12_next = sv_reg[2];
            cp12_next = sv_reg[1];

            px_next  = p1_reg * ct12_reg;
            pz_next  = p1_reg * st12_reg;
            nxo_next = rnd14(nx_reg);
            nzo_next = rnd14(nz_reg);
            nyo_next = cp12_reg;
            pyo_next = rnd14(py_reg);

            out_valid_next = vld_reg[PIPE_DEPTH-1];
            last_next      = side_reg[PIPE_DEPTH-1].last;
            err_next       = side_reg[PIPE_DEPTH-1].err;
            if (side_reg[PIPE_DEPTH-1].err)
            begin
                pos_x_next  = '0;
                pos_y_next  = '0;
                pos_z_next  = '0;
                norm_x_next = '0;
                norm_y_next = '0;
                norm_z_next = '0;
                tex_u_next  = '0;
                tex_v_next  = '0;
            end
            else
            begin
                pos_x_next  = rnd28(px_reg);
                pos_y_next  = pyo_reg;
                pos_z_next  = rnd28(pz_reg);
                norm_x_next = nxo_reg;
                norm_y_next = nyo_reg;
                norm_z_next = nzo_reg;
                tex_u_next  = side_reg[PIPE_DEPTH-1].u;
                tex_v_next  = side_reg[PIPE_DEPTH-1].v;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= 15'd256;
            segments_reg  <= 9'd32;
            rings_reg     <= 9'd16;
            busy_reg      <= 1'b0;
            corner_reg    <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            radius_reg    <= radius_next;
            segments_reg  <= segments_next;
            rings_reg     <= rings_next;
            busy_reg      <= busy_next;
            corner_reg    <= corner_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qr_reg     <= qr_next;
        qs_reg     <= qs_next;
        qerr_reg   <= qerr_next;
        side_reg   <= side_next;
        dv_reg     <= dv_next;
        dn_reg     <= dn_next;
        sn_reg     <= sn_next;
        sv_reg     <= sv_next;
        p1_reg     <= p1_next;
        nx_reg     <= nx_next;
        nz_reg     <= nz_next;
        py_reg     <= py_next;
        ct12_reg   <= ct12_next;
        st12_reg   <= st12_next;
        cp12_reg   <= cp12_next;
        px_reg     <= px_next;
        pz_reg     <= pz_next;
        nxo_reg    <= nxo_next;
        nyo_reg    <= nyo_next;
        nzo_reg    <= nzo_next;
        pyo_reg    <= pyo_next;
        pos_x_reg  <= pos_x_next;
        pos_y_reg  <= pos_y_next;
        pos_z_reg  <= pos_z_next;
        norm_x_reg <= norm_x_next;
        norm_y_reg <= norm_y_next;
        norm_z_reg <= norm_z_next;
        tex_u_reg  <= tex_u_next;
        tex_v_reg  <= tex_v_next;
        last_reg   <= last_next;
        err_reg    <= err_next;
    end

endmodule

/* hdl/uvsq_checker.sv */
// port-level checker for the uv sphere quad tessellator, bound to the top level
// depends on uv_sphere_quad_tessellator_top_assert.svh
`include "uv_sphere_quad_tessellator_top_assert.svh"

module uvsq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] pos_x,
    input logic signed [15:0] pos_y,
    input logic signed [15:0] norm_y,
    input logic [16:0]        tex_u,
    input logic [16:0]        tex_v,
    input logic               last_vertex,
    input logic               index_error
);

    `UVSQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pos_x) && $stable(tex_u), "output word changed while stalled")
    `UVSQ_ASSERT_IMP(a_err_last, out_valid && index_error, last_vertex, "error word not marked last")
    `UVSQ_ASSERT_IMP(a_err_zero, out_valid && index_error, pos_x == 16'sd0 && pos_y == 16'sd0 && tex_u == 17'd0 && tex_v == 17'd0, "error word carries data")
    `UVSQ_ASSERT_IMP(a_norm_range, out_valid, norm_y <= 16'sd16384 && norm_y >= -16'sd16384, "normal out of unit range")

endmodule

bind uv_sphere_quad_tessellator_top uvsq_checker u_uvsq_checker (.*);

/* dv/uvsq_vertex_checker.sv */
// vertex checker for the uv sphere quad tessellator: watches the quad and vertex channels,
// predicts six corners per in-range quad, one error word otherwise; compares whole words
// depends on uvsq_pkg for register indexes and corner steps
module uvsq_vertex_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         ring_index,
    input  logic [7:0]         segment_index,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic signed [15:0] norm_x,
    input  logic signed [15:0] norm_y,
    input  logic signed [15:0] norm_z,
    input  logic [16:0]        tex_u,
    input  logic [16:0]        tex_v,
    input  logic               last_vertex,
    input  logic               index_error,
    output int                 fail_count,
    output int                 pending_vertices,
    output int                 quad_count,
    output int                 error_quad_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import uvsq_pkg::*;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [16:0]        u;
        logic [16:0]        v;
        logic               last;
        logic               err;
    } vertex_t;

    vertex_t expected_vertices[$];
    logic [14:0] radius_q;
    logic [8:0]  seg_cnt;
    logic [8:0]  ring_cnt;

    localparam longint unsigned SIN_COEF [6] = '{1686629713, 693598668, 85569306,
                                                  5026995, 172274, 3864};

    function automatic longint quadrant_sine(longint unsigned f);
        longint unsigned x, x2, p, r;
        x = f << 16;
        x2 = (x * x) >> 30;
        p = SIN_COEF[5];
        for (int i = 4; i >= 0; i--)
            p = SIN_COEF[i] - ((x2 * p) >> 30);
        r = (x * p) >> 30;
        r = (r + 32768) >> 16;
        if (r > 16384)
            r = 16384;
        return longint'(r);
    endfunction

    function automatic longint phase_sine(longint unsigned ph);
        longint unsigned q, f;
        longint m;
        ph = ph & 16'hFFFF;
        q = ph >> 14;
        f = ph & 14'h3FFF;
        m = q[0] ? quadrant_sine(16384 - f) : quadrant_sine(f);
        return q[1] ? -m : m;
    endfunction

    function automatic longint round_away(longint v, int sh);
        longint unsigned half;
        half = 64'd1 << (sh - 1);
        if (v < 0)
            return -longint'((longint'(-v) + half) >> sh);
        return longint'((longint'(v) + half) >> sh);
    endfunction

    function automatic vertex_t corner_vertex(longint unsigned rr, longint unsigned ss,
                                              longint unsigned rings, longint unsigned segs);
        vertex_t vx;
        longint unsigned u, v, pph;
        longint sp, cp, st, ct, rad;
        u = (ss * 65536 + segs / 2) / segs;
        v = (rr * 65536 + rings / 2) / rings;
        pph = (rr * 32768 + rings / 2) / rings;
        sp = phase_sine(pph);
        cp = phase_sine(pph + 16384);
        st = phase_sine(u & 16'hFFFF);
        ct = phase_sine((u & 16'hFFFF) + 16384);
        rad = longint'(radius_q);
        vx.px = 16'(round_away(rad * sp * ct, 28));
        vx.py = 16'(round_away(rad * cp, 14));
        vx.pz = 16'(round_away(rad * sp * st, 28));
        vx.nx = 16'(round_away(sp * ct, 14));
        vx.ny = 16'(cp);
        vx.nz = 16'(round_away(sp * st, 14));
        vx.u = 17'(u);
        vx.v = 17'(v);
        vx.last = 1'b0;
        vx.err = 1'b0;
        return vx;
    endfunction

    task automatic expand_quad(input logic [7:0] r, input logic [7:0] s);
        longint unsigned segs, rings;
        vertex_t vx;
        segs = (seg_cnt > 256) ? 256 : seg_cnt;
        rings = (ring_cnt > 256) ? 256 : ring_cnt;
        quad_count++;
        if (r >= rings || s >= segs) begin
            vx = '0;
            vx.last = 1'b1;
            vx.err = 1'b1;
            expected_vertices = {expected_vertices, vx};
            error_quad_count++;
        end
        else begin
            for (int k = 0; k < 6; k++) begin
                vx = corner_vertex(longint'(r) + longint'(CORNER_DR[k]),
                                   longint'(s) + longint'(CORNER_DS[k]), rings, segs);
                vx.last = (k == 5);
                expected_vertices = {expected_vertices, vx};
            end
        end
    endtask

    initial
    begin
        fail_count = 0;
        quad_count = 0;
        error_quad_count = 0;
    end

    assign pending_vertices = expected_vertices.size();

    always @(posedge clk or negedge rst_n)
    begin
        vertex_t got, want;
        if (!rst_n) begin
            radius_q <= 15'd256;
            seg_cnt <= 9'd32;
            ring_cnt <= 9'd16;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_RADIUS:   radius_q <= cfg_data;
                    REG_SEGMENTS: seg_cnt <= cfg_data[8:0];
                    REG_RINGS:    ring_cnt <= cfg_data[8:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expand_quad(ring_index, segment_index);
            if (out_valid && out_ready) begin
                got = '{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                        last_vertex, index_error};
                if (expected_vertices.size() == 0) begin
                    $display("%t: unexpected vertex word %p", $time, got);
                    fail_count++;
                end
                else begin
                    want = expected_vertices.pop_front();
                    if (got !== want) begin
                        $display("%t: vertex mismatch expected %p actual %p",
                                 $time, want, got);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

/* dv/tb.sv */
// testbench top for the uv sphere quad tessellator: drives configuration, quads and receiver
// stalls, gives the verdict; depends on uvsq_pkg, uv_sphere_quad_tessellator_top and uvsq_vertex_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import uvsq_pkg::*;

    logic clk, rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [14:0] cfg_data;
    logic in_valid, in_ready;
    logic [7:0] ring_index, segment_index;
    logic out_valid, out_ready;
    logic signed [15:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
    logic [16:0] tex_u, tex_v;
    logic last_vertex, index_error;
    int fail_count, pending_vertices, quad_count, error_quad_count;
    bit long_hold;
    logic [8:0] segs_now, rings_now;

    uv_sphere_quad_tessellator_top dut (.*);
    uvsq_vertex_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("uv_sphere_quad_tessellator_top test failed");
        $finish;
    end

    // receiver: random stalls, one long hold-off
    initial
    begin
        int w;
        out_ready = 0;
        @(posedge rst_n);
        forever begin
            if (long_hold) begin
                out_ready <= 0;
                repeat (200) @(posedge clk);
                long_hold = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (w > 0) begin
                out_ready <= 0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
        end
    end

    // cfg_we stays high between back-to-back writes, the caller drops it
    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic set_shape(input logic [14:0] rad, input logic [8:0] segs,
                             input logic [8:0] rings);
        in_valid <= 0;
        @(posedge clk);
        while (pending_vertices != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_SEGMENTS, {6'h0, segs});
        write_reg(REG_RINGS, {6'h0, rings});
        cfg_we <= 0;
        segs_now = segs;
        rings_now = rings;
    endtask

    // in_valid stays high after acceptance, the next word or the caller drops it
    task automatic send_quad(input logic [7:0] r, input logic [7:0] s, input bit gaps);
        int w;
        w = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5)) : 0;
        if (w > 0) begin
            in_valid <= 0;
            repeat (w) @(posedge clk);
        end
        in_valid <= 1;
        ring_index <= r;
        segment_index <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic random_quads(input int n);
        logic [7:0] r, s;
        bit gaps;
        gaps = 1'($urandom_range(0, 1));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                r = 8'($urandom);
                s = 8'($urandom);
            end
            else begin
                r = 8'($urandom_range(0, (rings_now > 256 ? 256 : rings_now) - 1));
                s = 8'($urandom_range(0, (segs_now > 256 ? 256 : segs_now) - 1));
            end
            send_quad(r, s, gaps);
        end
    endtask

    initial
    begin
        cfg_we = 0;
        cfg_index = REG_RADIUS;
        cfg_data = 0;
        in_valid = 0;
        ring_index = 0;
        segment_index = 0;
        long_hold = 0;
        segs_now = 32;
        rings_now = 16;
        rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed, from the reset shape on: poles, seams, out of range
        send_quad(0, 0, 0);
        send_quad(15, 31, 0);
        send_quad(7, 16, 1);
        send_quad(16, 0, 0);
        send_quad(0, 32, 0);
        send_quad(255, 255, 0);
        send_quad(8'hAA, 8'h55, 0);
        send_quad(8'h55, 8'hAA, 0);
        set_shape(15'h7FFF, 9'd256, 9'd256);
        send_quad(255, 255, 0);
        send_quad(0, 0, 0);
        send_quad(128, 200, 0);
        set_shape(15'd0, 9'd1, 9'd1);
        send_quad(0, 0, 0);
        send_quad(1, 0, 0);
        send_quad(0, 1, 0);
        set_shape(15'd1000, 9'd511, 9'd300);
        send_quad(255, 255, 0);
        send_quad(0, 0, 0);
        set_shape(15'd500, 9'd0, 9'd0);
        send_quad(0, 0, 0);
        send_quad(3, 3, 0);

        set_shape(15'd256, 9'd32, 9'd16);
        long_hold = 1;
        random_quads(40);
        set_shape(15'($urandom_range(0, 32767)), 9'($urandom_range(3, 64)),
                  9'($urandom_range(2, 64)));
        random_quads(60);
        set_shape(15'($urandom_range(0, 32767)), 9'($urandom_range(1, 256)),
                  9'($urandom_range(1, 256)));
        random_quads(60);
        set_shape(15'h7FFF, 9'd3, 9'd2);
        random_quads(60);
        set_shape(15'($urandom_range(0, 32767)), 9'($urandom_range(0, 511)),
                  9'($urandom_range(0, 511)));
        random_quads(60);

        in_valid <= 0;
        @(posedge clk);
        while (pending_vertices != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        $display("covered %0d quads, %0d out of range, over several radius and count settings",
                 quad_count, error_quad_count);
        if (fail_count == 0)
            $display("uv_sphere_quad_tessellator_top test passed");
        else
            $display("uv_sphere_quad_tessellator_top test failed");
        $finish;
    end
endmodule
